>>> hdl/lpcs_pkg.sv
// Shared types, constants and mu-law tables for the LPC excitation synthesis core.
// No dependencies; imported by the top level, lpcs_tap_mem, lpcs_mulaw_enc and lpcs_deemph.
`default_nettype none

package lpcs_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_PREDICT = 2'd1,
    KIND_EXCITE  = 2'd2
  } kind_e;

  localparam logic RES_PREDICT = 1'b0;
  localparam logic RES_SAMPLE  = 1'b1;

  localparam logic [15:0] GAIN_RESET = 16'd55706;
  localparam logic [7:0]  MU_MID     = 8'd128;
  localparam int          EXP_DEPTH  = 129;

  // round(2^(f/16) * 2^24)
  localparam logic [24:0] EXPT [16] = '{
    25'd16777216, 25'd17520007, 25'd18295684, 25'd19105703,
    25'd19951585, 25'd20834917, 25'd21757357, 25'd22720638,
    25'd23726566, 25'd24777031, 25'd25874004, 25'd27019544,
    25'd28215801, 25'd29465022, 25'd30769550, 25'd32131834
  };

  // round(2^((2j+1)/32) * 2^24), half-way points between codes
  localparam logic [24:0] THR [16] = '{
    25'd17144589, 25'd17903645, 25'd18696307, 25'd19524063,
    25'd20388467, 25'd21291142, 25'd22233781, 25'd23218155,
    25'd24246111, 25'd25319578, 25'd26440571, 25'd27611195,
    25'd28833647, 25'd30110222, 25'd31443315, 25'd32835429
  };

  typedef struct packed {
    logic               coef_we;
    logic [3:0]         coef_idx;
    logic signed [15:0] coef_val;
    logic               push;
    logic signed [23:0] push_val;
  } tap_cmd_t;

  // Magnitude of the mu-law expansion for |code - 128| = m; elaboration only.
  function automatic logic [31:0] mulaw_expand(logic [7:0] m, int unsigned frac);
    logic [63:0] x;
    logic [63:0] v;
    x = (64'(EXPT[m[3:0]]) << m[7:4]) - 64'd16777216;
    v = ((x << frac) + 64'd65280) / 64'd130560;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/lpcs_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
`default_nettype none

interface lpcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [3:0]         coef_index;
  logic signed [15:0] coef_value;
  logic [7:0]         exc_code;

  modport source (output valid, kind, coef_index, coef_value, exc_code, input ready);
  modport sink   (input valid, kind, coef_index, coef_value, exc_code, output ready);
endinterface

interface lpcs_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         pred_code;
  logic signed [23:0] pcm_value;
  logic [7:0]         pcm_code;
  logic signed [15:0] out_sample;

  modport source (output valid, result_kind, pred_code, pcm_value, pcm_code, out_sample,
                  input ready);
  modport sink   (input valid, result_kind, pred_code, pcm_value, pcm_code, out_sample,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/lpc_excitation_synthesis.sv
// Top level of the LPC excitation synthesis core: sequencer, expansion ROM, output register.
// Depends on lpcs_pkg, lpcs_if, lpcs_tap_mem, lpcs_mac, lpcs_mulaw_enc, lpcs_deemph.
//
//   port          dir  handshake          carries
//   in_i          in   valid/ready        kind, coef_index, coef_value, exc_code
//   out_o         out  valid/ready        result_kind, pred_code, pcm_value, pcm_code, out_sample
//   cfg_we_i      in   write enable only  cfg_wdata_i = de-emphasis gain, Q0.16
//
// One item at a time. A load is written straight into the tap memory. A predict reads one tap
// per cycle through the single memory read port and multiplier, then runs 8 search steps in the
// mu-law encoder. An excite waits on the encoder search and the de-emphasis filter.
// The output register holds a result while out_o stalls; the next item is taken meanwhile.
// Reset is asynchronous, active low; no clearing pass, the tap memories are ready at once.
`default_nettype none

module lpc_excitation_synthesis
  import lpcs_pkg::*;
#(
  parameter int ORDER_TAPS       = 16,
  parameter int SAMPLE_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  lpcs_in_if.sink     in_i,
  lpcs_out_if.source  out_o
);

  localparam int TAP_W = (ORDER_TAPS > 1) ? $clog2(ORDER_TAPS) : 1;
  localparam int ACC_W = 40 + $clog2(ORDER_TAPS);
  localparam int VW    = 16 + SAMPLE_FRAC_BITS;
  localparam int SUM_W = ((VW > 24) ? VW : 24) + 2;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MAC   = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_PRED  = 7'b0001000,
    ST_PENC  = 7'b0010000,
    ST_EXC   = 7'b0100000,
    ST_XWAIT = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [TAP_W-1:0]   k_q, k_d;
  logic [15:0]        gain_q;
  logic [7:0]         exc_q;
  logic signed [23:0] pred_q, smp_q;
  logic [7:0]         pred_code_q;

  logic               out_valid_q;
  logic               out_kind_q;
  logic [7:0]         out_pred_code_q, out_pcm_code_q;
  logic signed [23:0] out_pcm_q;
  logic signed [15:0] out_smp_q;

  logic accept, out_free, emit_pred, emit_smp;

  tap_cmd_t                tap_cmd;
  logic                    rd_valid, mac_busy, enc_busy, dm_busy;
  logic signed [15:0]      rd_coef, dm_out;
  logic signed [23:0]      rd_hist, enc_x;
  logic signed [ACC_W-1:0] mac_acc;
  logic [7:0]              enc_code;

  // mu-law expansion magnitudes
  logic [VW-1:0] exp_rom [EXP_DEPTH];
  for (genvar g = 0; g < EXP_DEPTH; g++) begin : g_exp
    localparam logic [31:0] EV = mulaw_expand(8'(g), SAMPLE_FRAC_BITS);
    assign exp_rom[g] = EV[VW-1:0];
  end

  logic signed [ACC_W:0]   neg_s, pred_sh;
  logic signed [23:0]      pred_sat, smp_sat;
  logic [7:0]              m;
  logic signed [SUM_W-1:0] ev_s, smp_sum;

  always_comb begin
    neg_s   = (ACC_W+1)'(2048) - (ACC_W+1)'(mac_acc);
    pred_sh = neg_s >>> 12;
    if (pred_sh[ACC_W:23] == '0 || pred_sh[ACC_W:23] == '1) begin
      pred_sat = pred_sh[23:0];
    end else begin
      pred_sat = pred_sh[ACC_W] ? 24'sh80_0000 : 24'sh7F_FFFF;
    end

    m       = (exc_q >= MU_MID) ? exc_q - MU_MID : MU_MID - exc_q;
    ev_s    = $signed(SUM_W'(exp_rom[m]));
    smp_sum = SUM_W'(pred_q) + ((exc_q < MU_MID) ? -ev_s : ev_s);
    if (smp_sum[SUM_W-1:23] == '0 || smp_sum[SUM_W-1:23] == '1) begin
      smp_sat = smp_sum[23:0];
    end else begin
      smp_sat = smp_sum[SUM_W-1] ? 24'sh80_0000 : 24'sh7F_FFFF;
    end
  end

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    tap_cmd.coef_we  = accept && (in_i.kind == KIND_LOAD) &&
                       (32'(in_i.coef_index) < ORDER_TAPS);
    tap_cmd.coef_idx = in_i.coef_index;
    tap_cmd.coef_val = in_i.coef_value;
    tap_cmd.push     = (state_q == ST_EXC);
    tap_cmd.push_val = smp_sat;
    enc_x            = (state_q == ST_PRED) ? pred_sat : smp_sat;
  end

  assign emit_pred = (state_q == ST_PENC) && !enc_busy && out_free;
  assign emit_smp  = (state_q == ST_XWAIT) && !enc_busy && !dm_busy && out_free;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (accept) begin
          unique case (in_i.kind)
            KIND_PREDICT: state_d = ST_MAC;
            KIND_EXCITE:  state_d = ST_EXC;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_MAC: begin
        if (k_q == TAP_W'(ORDER_TAPS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + TAP_W'(1);
        end
      end
      ST_DRAIN: if (!rd_valid && !mac_busy) state_d = ST_PRED;
      ST_PRED:  state_d = ST_PENC;
      ST_PENC:  if (emit_pred) state_d = ST_IDLE;
      ST_EXC:   state_d = ST_XWAIT;
      ST_XWAIT: if (emit_smp) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      gain_q      <= GAIN_RESET;
      pred_q      <= '0;
      pred_code_q <= MU_MID;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (state_q == ST_PRED) begin
        pred_q <= pred_sat;
      end
      if (emit_pred) begin
        pred_code_q <= enc_code;
      end
      if (emit_pred || emit_smp) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      exc_q <= in_i.exc_code;
    end
    if (state_q == ST_EXC) begin
      smp_q <= smp_sat;
    end
    if (emit_pred) begin
      out_kind_q      <= RES_PREDICT;
      out_pred_code_q <= enc_code;
      out_pcm_q       <= '0;
      out_pcm_code_q  <= '0;
      out_smp_q       <= '0;
    end else if (emit_smp) begin
      out_kind_q      <= RES_SAMPLE;
      out_pred_code_q <= pred_code_q;
      out_pcm_q       <= smp_q;
      out_pcm_code_q  <= enc_code;
      out_smp_q       <= dm_out;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.pred_code   = out_pred_code_q;
  assign out_o.pcm_value   = out_pcm_q;
  assign out_o.pcm_code    = out_pcm_code_q;
  assign out_o.out_sample  = out_smp_q;

  lpcs_tap_mem #(
    .ORDER_TAPS (ORDER_TAPS)
  ) u_tap_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tap_cmd),
    .rd_en_i    (state_q == ST_MAC),
    .rd_tap_i   (k_q),
    .rd_valid_o (rd_valid),
    .coef_o     (rd_coef),
    .hist_o     (rd_hist)
  );

  lpcs_mac #(
    .ORDER_TAPS (ORDER_TAPS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (accept && (in_i.kind == KIND_PREDICT)),
    .in_valid_i (rd_valid),
    .coef_i     (rd_coef),
    .hist_i     (rd_hist),
    .busy_o     (mac_busy),
    .acc_o      (mac_acc)
  );

  lpcs_mulaw_enc #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
  ) u_enc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == ST_PRED) || (state_q == ST_EXC)),
    .x_i     (enc_x),
    .busy_o  (enc_busy),
    .code_o  (enc_code)
  );

  lpcs_deemph #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
  ) u_deemph (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (state_q == ST_EXC),
    .gain_i       (gain_q),
    .sample_i     (smp_sat),
    .busy_o       (dm_busy),
    .out_sample_o (dm_out)
  );

endmodule

`default_nettype wire

>>> hdl/lpcs_tap_mem.sv
// Coefficient and sample history memories with registered read.
// History is a circular buffer; valid bits and a fill count stand for the zero reset.
// Depends on lpcs_pkg.
`default_nettype none

module lpcs_tap_mem
  import lpcs_pkg::*;
#(
  parameter int ORDER_TAPS = 16,
  localparam int TAP_W = (ORDER_TAPS > 1) ? $clog2(ORDER_TAPS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tap_cmd_t           cmd_i,
  input  logic               rd_en_i,
  input  logic [TAP_W-1:0]   rd_tap_i,
  output logic               rd_valid_o,
  output logic signed [15:0] coef_o,
  output logic signed [23:0] hist_o
);

  localparam int FILL_W = $clog2(ORDER_TAPS + 1);

  logic signed [15:0] coef_mem [ORDER_TAPS];
  logic signed [23:0] hist_mem [ORDER_TAPS];

  logic [ORDER_TAPS-1:0] coef_vld_q;
  logic [TAP_W-1:0]      wp_q;
  logic [FILL_W-1:0]     fill_q;
  logic                  rvalid_q;
  logic                  coef_ok_q, hist_ok_q;
  logic signed [15:0]    coef_rd_q;
  logic signed [23:0]    hist_rd_q;

  logic [TAP_W:0]   hsum;
  logic [TAP_W-1:0] haddr, caddr;
  logic             hist_ok;

  // tap k sits k entries behind the newest sample
  always_comb begin
    hsum  = (TAP_W+1)'(wp_q) + (TAP_W+1)'(ORDER_TAPS - 1) - (TAP_W+1)'(rd_tap_i);
    haddr = (hsum >= (TAP_W+1)'(ORDER_TAPS)) ? TAP_W'(hsum - (TAP_W+1)'(ORDER_TAPS))
                                              : hsum[TAP_W-1:0];
    hist_ok = (TAP_W+1)'(haddr) < (TAP_W+1)'(fill_q);
    caddr   = TAP_W'(cmd_i.coef_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      rvalid_q   <= 1'b0;
      coef_ok_q  <= 1'b0;
      hist_ok_q  <= 1'b0;
    end else begin
      rvalid_q <= rd_en_i;
      if (rd_en_i) begin
        coef_ok_q <= coef_vld_q[rd_tap_i];
        hist_ok_q <= hist_ok;
      end
      if (cmd_i.coef_we) begin
        coef_vld_q[caddr] <= 1'b1;
      end
      if (cmd_i.push) begin
        wp_q <= (wp_q == TAP_W'(ORDER_TAPS - 1)) ? '0 : wp_q + TAP_W'(1);
        if (fill_q != FILL_W'(ORDER_TAPS)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we) begin
      coef_mem[caddr] <= cmd_i.coef_val;
    end
    if (cmd_i.push) begin
      hist_mem[wp_q] <= cmd_i.push_val;
    end
    if (rd_en_i) begin
      coef_rd_q <= coef_mem[rd_tap_i];
      hist_rd_q <= hist_mem[haddr];
    end
  end

  assign rd_valid_o = rvalid_q;
  assign coef_o     = coef_ok_q ? coef_rd_q : '0;
  assign hist_o     = hist_ok_q ? hist_rd_q : '0;

endmodule

`default_nettype wire

>>> hdl/lpcs_mac.sv
// Prediction multiply-accumulate: registered 16x24 product, exact running sum.
// Depends on nothing.
`default_nettype none

module lpcs_mac
#(
  parameter int ORDER_TAPS = 16,
  localparam int ACC_W = 40 + $clog2(ORDER_TAPS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    in_valid_i,
  input  logic signed [15:0]      coef_i,
  input  logic signed [23:0]      hist_i,
  output logic                    busy_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [39:0]      prod_q;
  logic                    prod_v_q;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= in_valid_i;
      priority if (clear_i) begin
        acc_q <= '0;
      end else if (prod_v_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      prod_q <= coef_i * hist_i;
    end
  end

  assign busy_o = prod_v_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

>>> hdl/lpcs_mulaw_enc.sv
// Mu-law (mu = 255) compressor: 8-step binary search over the 128 decision thresholds.
// Depends on lpcs_pkg (THR table, MU_MID).
`default_nettype none

module lpcs_mulaw_enc
  import lpcs_pkg::*;
#(
  parameter int SAMPLE_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [23:0] x_i,
  output logic               busy_o,
  output logic [7:0]         code_o
);

  localparam int LSH = 15 + SAMPLE_FRAC_BITS;

  logic        busy_q, neg_q, zero_q;
  logic [2:0]  b_q;
  logic [7:0]  c_q;
  logic [32:0] l_q;

  logic [23:0] mag;
  logic [32:0] l_d;
  logic [8:0]  cand;
  logic [6:0]  n;
  logic [63:0] lhs, rhs;
  logic        hit;

  always_comb begin
    mag  = x_i[23] ? 24'(-x_i) : 24'(x_i);
    l_d  = (33'd1 << LSH) + {1'b0, mag, 8'd0} - 33'(mag);
    cand = {1'b0, c_q} + (9'd1 << b_q);
    n    = 7'(cand - 9'd1);
    lhs  = {7'd0, l_q, 24'd0};
    rhs  = (64'(THR[n[3:0]]) << n[6:4]) << LSH;
    hit  = (cand <= 9'd128) && (lhs >= rhs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      b_q    <= '0;
      c_q    <= '0;
      neg_q  <= 1'b0;
      zero_q <= 1'b1;
      l_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      b_q    <= 3'd7;
      c_q    <= '0;
      neg_q  <= x_i[23];
      zero_q <= (x_i == '0);
      l_q    <= l_d;
    end else if (busy_q) begin
      if (hit) begin
        c_q <= cand[7:0];
      end
      if (b_q == 3'd0) begin
        busy_q <= 1'b0;
      end else begin
        b_q <= b_q - 3'd1;
      end
    end
  end

  always_comb begin
    priority if (zero_q) begin
      code_o = MU_MID;
    end else if (neg_q) begin
      code_o = MU_MID - c_q;
    end else begin
      code_o = MU_MID + ((c_q > 8'd127) ? 8'd127 : c_q);
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

>>> hdl/lpcs_deemph.sv
// De-emphasis: mem = sat32(round(gain*mem / 2^16) + sample), output mem / 2^F to int16.
// Registered 17x32 product, then round, add and saturate. Depends on lpcs_pkg.
`default_nettype none

module lpcs_deemph
  import lpcs_pkg::*;
#(
  parameter int SAMPLE_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        gain_i,
  input  logic signed [23:0] sample_i,
  output logic               busy_o,
  output logic signed [15:0] out_sample_o
);

  localparam logic [32:0] TRUNC_BIAS = 33'((64'd1 << SAMPLE_FRAC_BITS) - 64'd1);

  logic               busy_q;
  logic signed [31:0] acc_q;
  logic signed [48:0] prod_q;
  logic signed [23:0] smp_q;

  logic signed [48:0] prod_d;
  logic signed [32:0] rnd;
  logic signed [34:0] sum;
  logic signed [31:0] acc_d;
  logic signed [32:0] adj, quo;

  always_comb begin
    prod_d = $signed({1'b0, gain_i}) * acc_q;
    rnd    = prod_q[48:16] + 33'(prod_q[15]);
    sum    = 35'(rnd) + 35'(smp_q);
    if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
      acc_d = sum[31:0];
    end else begin
      acc_d = sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    // truncate toward zero
    adj = 33'(acc_q) + (acc_q[31] ? TRUNC_BIAS : 33'd0);
    quo = adj >>> SAMPLE_FRAC_BITS;
    if (quo[32:15] == '0 || quo[32:15] == '1) begin
      out_sample_o = quo[15:0];
    end else begin
      out_sample_o = quo[32] ? 16'sh8000 : 16'sh7FFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      busy_q <= start_i;
      if (busy_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
      smp_q  <= sample_i;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire
